// ----- design/abst_pkg.sv -----
// Shared types and constants for the array binary search tree unit.
// Used by abst_ctrl, abst_datapath and array_binary_search_tree_unit.
package abst_pkg;

    localparam int NODE_SLOTS = 63;
    localparam int SLOT_W     = $clog2(NODE_SLOTS + 1);
    localparam int IDX_W      = SLOT_W + 1;
    localparam int KEY_W      = 32;

    // request commands
    localparam logic CMD_INSERT   = 1'b0;
    localparam logic CMD_TRAVERSE = 1'b1;

    // walk orders; the unused code walks in postorder
    localparam logic [1:0] ORDER_PRE  = 2'd0;
    localparam logic [1:0] ORDER_IN   = 2'd1;
    localparam logic [1:0] ORDER_POST = 2'd2;

    // result kinds and status codes
    localparam logic       KIND_INSERT = 1'b0;
    localparam logic       KIND_WALK   = 1'b1;
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;

    // index moves
    localparam logic [1:0] NAV_NONE  = 2'd0;
    localparam logic [1:0] NAV_LEFT  = 2'd1;
    localparam logic [1:0] NAV_RIGHT = 2'd2;
    localparam logic [1:0] NAV_UP    = 2'd3;

    // result sources
    localparam logic [2:0] RES_OK    = 3'd0;
    localparam logic [2:0] RES_ZERO  = 3'd1;
    localparam logic [2:0] RES_FULL  = 3'd2;
    localparam logic [2:0] RES_PEND  = 3'd3;
    localparam logic [2:0] RES_EMPTY = 3'd4;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] key_in;
        logic [1:0]              walk_order;
    } request_t;

    typedef struct packed {
        logic                    result_kind;
        logic [1:0]              status;
        logic signed [KEY_W-1:0] key_out;
        logic [SLOT_W-1:0]       slot;
        logic                    last;
    } result_t;

    typedef struct packed {
        logic       load;
        logic [1:0] nav;
        logic       write;
        logic       emit;
        logic       push;
        logic [2:0] push_sel;
        logic       push_last;
    } cmd_t;

    typedef struct packed {
        logic key_zero;
        logic node_empty;
        logic idx_oor;
        logic key_less;
        logic is_left;
        logic is_root;
        logic pend_valid;
        logic out_free;
        logic order_pre;
        logic order_in;
        logic order_post;
    } status_t;

endpackage

// ----- design/abst_datapath.sv -----
// Datapath: node store with valid bits, walk index, request latch,
// pending traversal element and the result register. Depends on abst_pkg.
module abst_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  abst_pkg::request_t request,
    input  abst_pkg::cmd_t     cmd,
    output abst_pkg::status_t  st,
    output logic               result_valid,
    input  logic               result_ready,
    output abst_pkg::result_t  result
);

    logic signed [abst_pkg::KEY_W-1:0] node_mem [abst_pkg::NODE_SLOTS];
    logic [abst_pkg::NODE_SLOTS-1:0]   node_vld_reg;

    logic [abst_pkg::IDX_W-1:0]        idx_reg;
    logic [abst_pkg::IDX_W-1:0]        idx_next;
    logic signed [abst_pkg::KEY_W-1:0] key_reg;
    logic [1:0]                        order_reg;
    logic signed [abst_pkg::KEY_W-1:0] rd_key_reg;
    logic                              rd_vld_reg;
    logic signed [abst_pkg::KEY_W-1:0] pend_key_reg;
    logic [abst_pkg::SLOT_W-1:0]       pend_slot_reg;
    logic                              pend_valid_reg;
    logic                              out_valid_reg;
    abst_pkg::result_t                 out_reg;
    abst_pkg::result_t                 out_next;

    logic                              step;
    logic                              rd_in_range;
    logic [abst_pkg::SLOT_W-1:0]       rd_addr;
    logic [abst_pkg::SLOT_W-1:0]       idx_slot;
    logic                              out_free;

    assign step        = cmd.load || (cmd.nav != abst_pkg::NAV_NONE);
    assign rd_in_range = idx_next < abst_pkg::IDX_W'(abst_pkg::NODE_SLOTS);
    assign rd_addr     = idx_next[abst_pkg::SLOT_W-1:0];
    assign idx_slot    = idx_reg[abst_pkg::SLOT_W-1:0];
    assign out_free    = !out_valid_reg || result_ready;

    always_comb
    begin
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else
        begin
            unique case (cmd.nav)
                abst_pkg::NAV_LEFT:  idx_next = (idx_reg << 1) + abst_pkg::IDX_W'(1);
                abst_pkg::NAV_RIGHT: idx_next = (idx_reg << 1) + abst_pkg::IDX_W'(2);
                abst_pkg::NAV_UP:    idx_next = (idx_reg - abst_pkg::IDX_W'(1)) >> 1;
                default:             idx_next = idx_reg;
            endcase
        end
    end

    // store array: write at the end of an insert, read on every index move that stays in range
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            node_mem[idx_slot] <= key_reg;
        end
        if (step && rd_in_range)
        begin
            rd_key_reg <= node_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_vld_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                node_vld_reg[idx_slot] <= 1'b1;
            end
            if (step)
            begin
                idx_reg    <= idx_next;
                // a slot beyond the store reads as empty
                rd_vld_reg <= rd_in_range && node_vld_reg[rd_addr];
            end
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.push && cmd.push_sel == abst_pkg::RES_PEND)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= request.key_in;
            order_reg <= request.walk_order;
        end
        if (cmd.emit)
        begin
            pend_key_reg  <= rd_key_reg;
            pend_slot_reg <= idx_slot;
        end
        if (cmd.push)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        out_next.result_kind = abst_pkg::KIND_INSERT;
        out_next.status      = abst_pkg::STAT_OK;
        out_next.key_out     = '0;
        out_next.slot        = '0;
        out_next.last        = 1'b1;
        unique case (cmd.push_sel)
            abst_pkg::RES_OK:
            begin
                out_next.slot = idx_slot;
            end
            abst_pkg::RES_FULL:
            begin
                out_next.status = abst_pkg::STAT_FULL;
            end
            abst_pkg::RES_PEND:
            begin
                out_next.result_kind = abst_pkg::KIND_WALK;
                out_next.key_out     = pend_key_reg;
                out_next.slot        = pend_slot_reg;
                out_next.last        = cmd.push_last;
            end
            abst_pkg::RES_EMPTY:
            begin
                out_next.result_kind = abst_pkg::KIND_WALK;
                out_next.status      = abst_pkg::STAT_EMPTY;
            end
            default:
            begin
                out_next.slot = '0;
            end
        endcase
    end

    assign st.key_zero   = key_reg == '0;
    assign st.node_empty = !rd_vld_reg;
    assign st.idx_oor    = idx_reg >= abst_pkg::IDX_W'(abst_pkg::NODE_SLOTS);
    assign st.key_less   = key_reg < rd_key_reg;
    assign st.is_left    = idx_reg[0];
    assign st.is_root    = idx_reg == '0;
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = out_free;
    assign st.order_pre  = order_reg == abst_pkg::ORDER_PRE;
    assign st.order_in   = order_reg == abst_pkg::ORDER_IN;
    assign st.order_post = !st.order_pre && !st.order_in;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> !st.idx_oor && key_reg != '0)
        else $error("insert writes outside the store or writes an empty key");

    a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> out_free)
        else $error("result pushed into an occupied result register");

    a_emit_flushes_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && pend_valid_reg |->
            cmd.push && cmd.push_sel == abst_pkg::RES_PEND && !cmd.push_last)
        else $error("pending element overwritten without being pushed");

    a_down_from_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.nav == abst_pkg::NAV_LEFT || cmd.nav == abst_pkg::NAV_RIGHT) |->
            rd_vld_reg && !st.idx_oor)
        else $error("descent from an empty slot");

endmodule

// ----- design/abst_ctrl.sv -----
// Controller state machine: sequences inserts and stackless traversals.
// Drives abst_datapath through cmd_t and reads status_t; depends on abst_pkg.
module abst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              request_valid,
    output logic              request_ready,
    input  logic              command,
    input  abst_pkg::status_t st,
    output abst_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INSERT = 3'd1;
    localparam logic [2:0] S_DOWN   = 3'd2;
    localparam logic [2:0] S_UP     = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       from_left_reg;
    logic       from_left_next;
    logic       emit_ok;
    logic       want;

    assign emit_ok = !st.pend_valid || st.out_free;
    assign want    = from_left_reg ? st.order_in : st.order_post;

    always_comb
    begin
        state_next     = state_reg;
        from_left_next = from_left_reg;
        request_ready  = 1'b0;
        cmd            = '0;
        cmd.nav        = abst_pkg::NAV_NONE;
        cmd.push_sel   = abst_pkg::RES_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                request_ready = 1'b1;
                if (request_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (command == abst_pkg::CMD_INSERT) ? S_INSERT : S_DOWN;
                end
            end
            S_INSERT:
            begin
                if (st.key_zero || st.node_empty)
                begin
                    if (st.out_free)
                    begin
                        cmd.push      = 1'b1;
                        cmd.push_last = 1'b1;
                        if (st.key_zero)
                        begin
                            cmd.push_sel = abst_pkg::RES_ZERO;
                        end
                        else if (st.idx_oor)
                        begin
                            cmd.push_sel = abst_pkg::RES_FULL;
                        end
                        else
                        begin
                            cmd.write    = 1'b1;
                            cmd.push_sel = abst_pkg::RES_OK;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.nav = st.key_less ? abst_pkg::NAV_LEFT : abst_pkg::NAV_RIGHT;
                end
            end
            S_DOWN:
            begin
                if (st.node_empty)
                begin
                    if (st.is_root)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.nav        = abst_pkg::NAV_UP;
                        from_left_next = st.is_left;
                        state_next     = S_UP;
                    end
                end
                else if (!st.order_pre || emit_ok)
                begin
                    cmd.emit = st.order_pre;
                    cmd.nav  = abst_pkg::NAV_LEFT;
                end
            end
            S_UP:
            begin
                // back at a filled parent; hold while an element cannot move on
                if (!want || emit_ok)
                begin
                    cmd.emit = want;
                    if (from_left_reg)
                    begin
                        cmd.nav    = abst_pkg::NAV_RIGHT;
                        state_next = S_DOWN;
                    end
                    else if (st.is_root)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.nav        = abst_pkg::NAV_UP;
                        from_left_next = st.is_left;
                    end
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    cmd.push_sel  = st.pend_valid ? abst_pkg::RES_PEND : abst_pkg::RES_EMPTY;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // flush the previous element whenever a new one is taken
        if (cmd.emit && st.pend_valid)
        begin
            cmd.push      = 1'b1;
            cmd.push_sel  = abst_pkg::RES_PEND;
            cmd.push_last = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            from_left_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            from_left_reg <= from_left_next;
        end
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        request_ready |-> state_reg == S_IDLE && !cmd.push)
        else $error("request taken while a request is in progress");

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && st.out_free |=> state_reg == S_IDLE)
        else $error("traversal did not complete after its final result");

    a_up_from_child: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.nav == abst_pkg::NAV_UP |-> !st.is_root)
        else $error("walk climbed above the root");

endmodule

// ----- design/array_binary_search_tree_unit.sv -----
// Top level of the array binary search tree unit: controller plus datapath.
// Depends on abst_pkg, abst_ctrl and abst_datapath.
//
//  channel  | signals                               | payload type
//  ---------+---------------------------------------+-------------------
//  request  | request_valid, request_ready, request | abst_pkg::request_t
//  result   | result_valid, result_ready, result    | abst_pkg::result_t
//
// An insert walks the tree one level at a time, each level waiting on the
// registered store read of that level.
// A traversal does one store read per step of the stackless walk; new
// requests wait until it is done.
// Reset clears every slot at once through per-slot valid bits; no sweep.
// A stalled result holds an insert's last step and the traversal's end; the
// walk itself stops only when a second element must move on.
module array_binary_search_tree_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_ready,
    input  abst_pkg::request_t request,
    output logic               result_valid,
    input  logic               result_ready,
    output abst_pkg::result_t  result
);

    abst_pkg::cmd_t    cmd;
    abst_pkg::status_t st;

    abst_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .command       (request.command),
        .st            (st),
        .cmd           (cmd)
    );

    abst_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .st           (st),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
